// ===== design/jdv_pkg.sv =====
// ----------------------------------------------------------------------------
// jdv_pkg
// Shared types and constants for the joystick direction vote block.
// ----------------------------------------------------------------------------
package jdv_pkg;

  localparam int WINDOW      = 10;
  localparam int SAMPLE_BITS = 12;
  localparam int CNT_W       = $clog2(WINDOW + 1);
  localparam int DIR_KINDS   = 5;

  // axis select codes
  localparam logic [1:0] AXIS_NONE  = 2'd0;
  localparam logic [1:0] AXIS_VERT  = 2'd1;
  localparam logic [1:0] AXIS_HORIZ = 2'd2;

  // register indexes on the config channel
  localparam logic [1:0] REG_CENTER_X  = 2'd0;
  localparam logic [1:0] REG_CENTER_Y  = 2'd1;
  localparam logic [1:0] REG_DEADZONE  = 2'd2;
  localparam logic [1:0] REG_AXIS_MODE = 2'd3;

  typedef enum logic [2:0] {
    DIR_STOP  = 3'd0,
    DIR_UP    = 3'd1,
    DIR_DOWN  = 3'd2,
    DIR_LEFT  = 3'd3,
    DIR_RIGHT = 3'd4
  } dir_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] center_x;
    logic [SAMPLE_BITS-1:0] center_y;
    logic [SAMPLE_BITS-1:0] deadzone;
    logic [1:0]             axis_mode;
  } cfg_t;

  // contents of one window cell
  typedef struct packed {
    logic valid;
    dir_t code;
  } cell_t;

  // shift control broadcast along the cell row
  typedef struct packed {
    logic shift;
    dir_t code;
  } shift_ctrl_t;

endpackage

// ===== design/jdv_classify.sv =====
// ----------------------------------------------------------------------------
// jdv_classify
// Registered deadzone check: center offset, magnitude, compare, direction.
// ----------------------------------------------------------------------------
module jdv_classify (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            advance,
  input  logic                            in_valid,
  input  logic [jdv_pkg::SAMPLE_BITS-1:0] x_sample,
  input  logic [jdv_pkg::SAMPLE_BITS-1:0] y_sample,
  input  jdv_pkg::cfg_t                   cfg,
  output logic                            valid,
  output jdv_pkg::dir_t                   code
);

  localparam int OW = jdv_pkg::SAMPLE_BITS + 1;

  logic [jdv_pkg::SAMPLE_BITS-1:0] sample_sel;
  logic [jdv_pkg::SAMPLE_BITS-1:0] center_sel;
  logic signed [OW-1:0]            offset;
  logic [OW-1:0]                   mag;
  logic                            beyond;
  jdv_pkg::dir_t                   code_next;

  always_comb begin
    if (cfg.axis_mode == jdv_pkg::AXIS_VERT) begin
      sample_sel = y_sample;
      center_sel = cfg.center_y;
    end else begin
      sample_sel = x_sample;
      center_sel = cfg.center_x;
    end
    offset = $signed({1'b0, sample_sel}) - $signed({1'b0, center_sel});
    mag    = offset[OW-1] ? OW'(-offset) : OW'(offset);
    beyond = mag > {1'b0, cfg.deadzone};
  end

  always_comb begin
    case (cfg.axis_mode)
      jdv_pkg::AXIS_VERT: begin
        if (!beyond)          code_next = jdv_pkg::DIR_STOP;
        else if (offset[OW-1]) code_next = jdv_pkg::DIR_UP;
        else                  code_next = jdv_pkg::DIR_DOWN;
      end
      jdv_pkg::AXIS_HORIZ: begin
        if (!beyond)          code_next = jdv_pkg::DIR_STOP;
        else if (offset[OW-1]) code_next = jdv_pkg::DIR_RIGHT;
        else                  code_next = jdv_pkg::DIR_LEFT;
      end
      default: code_next = jdv_pkg::DIR_STOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (advance) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      code <= code_next;
    end
  end

endmodule

// ===== design/jdv_cell.sv =====
// ----------------------------------------------------------------------------
// jdv_cell
// One window slot; takes its neighbor's contents on every shift.
// ----------------------------------------------------------------------------
module jdv_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 shift,
  input  jdv_pkg::cell_t       d,
  output jdv_pkg::cell_t       q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (shift) begin
      q.valid <= d.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      q.code <= d.code;
    end
  end

endmodule

// ===== design/jdv_tally.sv =====
// ----------------------------------------------------------------------------
// jdv_tally
// Running per-direction counts over the window, and the majority pick.
// ----------------------------------------------------------------------------
module jdv_tally (
  input  logic                 clk,
  input  logic                 rst,
  input  jdv_pkg::shift_ctrl_t ctrl,
  input  jdv_pkg::cell_t       evicted,
  output jdv_pkg::dir_t        voted
);

  logic [jdv_pkg::CNT_W-1:0] cnt      [jdv_pkg::DIR_KINDS];
  logic [jdv_pkg::CNT_W-1:0] cnt_next [jdv_pkg::DIR_KINDS];
  logic [2:0]                best;

  always_comb begin
    for (int k = 0; k < jdv_pkg::DIR_KINDS; k++) begin
      cnt_next[k] = cnt[k];
      if (ctrl.code == 3'(k)) begin
        cnt_next[k] = cnt_next[k] + jdv_pkg::CNT_W'(1);
      end
      if (evicted.valid && evicted.code == 3'(k)) begin
        cnt_next[k] = cnt_next[k] - jdv_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < jdv_pkg::DIR_KINDS; k++) begin
        cnt[k] <= '0;
      end
    end else if (ctrl.shift) begin
      for (int k = 0; k < jdv_pkg::DIR_KINDS; k++) begin
        cnt[k] <= cnt_next[k];
      end
    end
  end

  // strict compare keeps the earlier code on a tie
  always_comb begin
    best = 3'(jdv_pkg::DIR_STOP);
    for (int k = 1; k < jdv_pkg::DIR_KINDS; k++) begin
      if (cnt[k] > cnt[best]) begin
        best = 3'(k);
      end
    end
    voted = jdv_pkg::dir_t'(best);
  end

endmodule

// ===== design/joystick_direction_vote.sv =====
// ----------------------------------------------------------------------------
// joystick_direction_vote
// Deadzone direction detection with a majority vote over recent samples.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one request per sample pair: tdata = {y_sample, x_sample}.
//   The block classifies the configured axis against center and deadzone,
//   pushes the code into a row of WINDOW cells, and returns on m_axis one
//   request per sample: tdata = {2'b0, instant_direction, voted_direction}.
//   Codes: 0 stop, 1 up, 2 down, 3 left, 4 right.
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
//   center_x, center_y, deadzone, axis_mode; cfg_ready is always high.
//   Write config only while no sample is in flight.
// Timing:
//   m_axis_tvalid rises after three register stages: classify register (loaded
//   at the s_axis accepting edge), cell row / running counts, output register.
//   One sample per cycle sustained while m_axis_tready stays high; the vote
//   reads running counts so the window never needs a full rescan.
// Reset:
//   rst clears the cells (all empty), the counts, the pipe and the config.
// Stall:
//   The whole pipe holds while the output register is full and m_axis_tready
//   is low; s_axis_tready drops in that same cycle.
// ----------------------------------------------------------------------------
module joystick_direction_vote (
  input  logic        clk,
  input  logic        rst,
  // slave: [11:0] x_sample, [23:12] y_sample
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,
  // master: [2:0] voted_direction, [5:3] instant_direction, [7:6] zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,
  // config write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data
);

  localparam int SB = jdv_pkg::SAMPLE_BITS;

  jdv_pkg::cfg_t        cfg;
  logic                 advance;

  logic                 s1_valid;
  jdv_pkg::dir_t        s1_code;
  logic                 s2_valid;
  jdv_pkg::dir_t        s2_code;

  logic                 out_valid;
  jdv_pkg::dir_t        out_voted;
  jdv_pkg::dir_t        out_instant;

  jdv_pkg::shift_ctrl_t ctrl;
  jdv_pkg::cell_t       link [jdv_pkg::WINDOW+1];
  jdv_pkg::dir_t        voted;

  // one stall for the whole pipe: move whenever the output slot frees up
  assign advance       = !out_valid || m_axis_tready;
  assign s_axis_tready = advance;
  assign cfg_ready     = 1'b1;

  // ---- configuration registers ----
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        jdv_pkg::REG_CENTER_X:  cfg.center_x  <= cfg_data[SB-1:0];
        jdv_pkg::REG_CENTER_Y:  cfg.center_y  <= cfg_data[SB-1:0];
        jdv_pkg::REG_DEADZONE:  cfg.deadzone  <= cfg_data[SB-1:0];
        jdv_pkg::REG_AXIS_MODE: cfg.axis_mode <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // ---- stage 1: classify ----
  jdv_classify u_classify (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .in_valid (s_axis_tvalid),
    .x_sample (s_axis_tdata[SB-1:0]),
    .y_sample (s_axis_tdata[2*SB-1:SB]),
    .cfg      (cfg),
    .valid    (s1_valid),
    .code     (s1_code)
  );

  // ---- stage 2: cell row and running counts ----
  assign ctrl.shift   = advance && s1_valid;
  assign ctrl.code    = s1_code;
  assign link[0].valid = 1'b1;
  assign link[0].code  = s1_code;

  for (genvar i = 0; i < jdv_pkg::WINDOW; i++) begin : g_cell
    jdv_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (ctrl.shift),
      .d     (link[i]),
      .q     (link[i+1])
    );
  end

  // oldest cell drops out as the new code enters
  jdv_tally u_tally (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ctrl),
    .evicted (link[jdv_pkg::WINDOW]),
    .voted   (voted)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (advance) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      s2_code <= s1_code;
    end
  end

  // ---- stage 3: output register; counts already include this sample ----
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s2_valid) begin
      out_voted   <= voted;
      out_instant <= s2_code;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {2'b00, out_instant, out_voted};

endmodule

// ===== design/jdv_checker.sv =====
// ----------------------------------------------------------------------------
// jdv_checker
// Port-level checks for joystick_direction_vote, bound to the top level.
// ----------------------------------------------------------------------------
module jdv_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tready,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [7:0]  m_axis_tdata,
  input  logic        cfg_ready
);

  // stalled output holds its request
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output request changed while stalled");

  // no output straight out of reset
  a_reset: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  // codes stay in the direction set
  a_codes: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[2:0] <= 3'(jdv_pkg::DIR_RIGHT) &&
                      m_axis_tdata[5:3] <= 3'(jdv_pkg::DIR_RIGHT))
    else $error("direction code out of range");

  // input is only held off while a result waits
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid || m_axis_tready |-> s_axis_tready)
    else $error("input stalled with free output slot");

  a_cfg: assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("config channel not ready");

endmodule

bind joystick_direction_vote jdv_checker u_jdv_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .cfg_ready     (cfg_ready)
);

// ===== bench/joystick_direction_vote_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// joystick_direction_vote_test
// Self-checking bench for the deadzone direction / majority vote block.
// A short list of directed requests (register writes and sample pairs) covers
// the field extremes, every axis mode, deadzone edges, ties and the empty
// window after reset. Random sample runs follow under eight register
// settings and four idling patterns on both stream sides. Every result is
// checked field by field against a local model of the ten-slot vote window.
// ----------------------------------------------------------------------------
module joystick_direction_vote_test;

  localparam int         STALL_LIMIT  = 2000;  // cycles with no handshake at all
  localparam int         ITEMS_PHASE  = 220;
  localparam int         PHASES       = 8;
  localparam int         TAIL_CYCLES  = 10;    // pipe is three deep
  localparam int         LONG_HOLD    = 120;
  localparam logic [1:0] AXIS_UNUSED  = 2'd3;  // undefined mode, acts as none
  localparam logic [2:0] SLOT_EMPTY   = 3'd5;
  localparam logic [11:0] S_MAX       = 12'hFFF;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;   // [11:0] x_sample, [23:12] y_sample
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;        // [2:0] voted, [5:3] instant, [7:6] pad
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = jdv_pkg::REG_CENTER_X;
  logic [11:0] cfg_data = '0;

  joystick_direction_vote u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  typedef struct packed {
    jdv_pkg::dir_t voted;
    jdv_pkg::dir_t instant;
  } vote_pair_t;

  // one directed request: a register write (a = value) or a sample (a = x, b = y)
  typedef struct packed {
    bit            is_reg;
    logic [1:0]    reg_index;
    logic [11:0]   a;
    logic [11:0]   b;
    bit            typed;
    jdv_pkg::dir_t voted;
    jdv_pkg::dir_t instant;
  } directed_row_t;

  localparam int N_DIRECTED = 35;
  localparam directed_row_t DIRECTED [N_DIRECTED] = '{
    // empty slots count for nothing, then a stop/down tie goes to stop
    '{1'b1, jdv_pkg::REG_AXIS_MODE, {10'd0, jdv_pkg::AXIS_VERT}, 12'd0,
      1'b0, jdv_pkg::DIR_STOP, jdv_pkg::DIR_STOP},
    '{1'b0, jdv_pkg::REG_CENTER_X, 12'd0, 12'd5,
      1'b1, jdv_pkg::DIR_DOWN, jdv_pkg::DIR_DOWN},
    '{1'b0, jdv_pkg::REG_CENTER_X, S_MAX, 12'd0,
      1'b1, jdv_pkg::DIR_STOP, jdv_pkg::DIR_STOP},
    '{1'b0, jdv_pkg::REG_CENTER_X, 12'd0, S_MAX,
      1'b1, jdv_pkg::DIR_DOWN, jdv_pkg::DIR_DOWN},
    '{1'b1, jdv_pkg::REG_AXIS_MODE, {10'd0, jdv_pkg::AXIS_NONE}, 12'd0,
      1'b0, jdv_pkg::DIR_STOP, jdv_pkg::DIR_STOP},
    '{1'b0, jdv_pkg::REG_CENTER_X, S_MAX, S_MAX,
      1'b1, jdv_pkg::DIR_STOP, jdv_pkg::DIR_STOP},
    '{1'b0, jdv_pkg::REG_CENTER_X, 12'd0, 12'd0,
      1'b1, jdv_pkg::DIR_STOP, jdv_pkg::DIR_STOP},
    // widest deadzone: full-scale offset is not above it
    '{1'b1, jdv_pkg::REG_CENTER_Y, S_MAX, 12'd0,
      1'b0, jdv_pkg::DIR_STOP, jdv_pkg::DIR_STOP},
    '{1'b1, jdv_pkg::REG_DEADZONE, S_MAX, 12'd0,
      1'b0, jdv_pkg::DIR_STOP, jdv_pkg::DIR_STOP},
    '{1'b1, jdv_pkg::REG_AXIS_MODE, {10'd0, jdv_pkg::AXIS_VERT}, 12'd0,
      1'b0, jdv_pkg::DIR_STOP, jdv_pkg::DIR_STOP},
    '{1'b0, jdv_pkg::REG_CENTER_X, S_MAX, 12'd0,
      1'b0, jdv_pkg::DIR_STOP, jdv_pkg::DIR_STOP},
    '{1'b1, jdv_pkg::REG_DEADZONE, 12'd4094, 12'd0,
      1'b0, jdv_pkg::DIR_STOP, jdv_pkg::DIR_STOP},
    '{1'b0, jdv_pkg::REG_CENTER_X, 12'd0, 12'd0,
      1'b0, jdv_pkg::DIR_STOP, jdv_pkg::DIR_STOP},
    // deadzone edges on the vertical axis
    '{1'b1, jdv_pkg::REG_CENTER_Y, 12'd2048, 12'd0,
      1'b0, jdv_pkg::DIR_STOP, jdv_pkg::DIR_STOP},
    '{1'b1, jdv_pkg::REG_DEADZONE, 12'd100, 12'd0,
      1'b0, jdv_pkg::DIR_STOP, jdv_pkg::DIR_STOP},
    '{1'b0, jdv_pkg::REG_CENTER_X, S_MAX, 12'd2148,
      1'b0, jdv_pkg::DIR_STOP, jdv_pkg::DIR_STOP},
    '{1'b0, jdv_pkg::REG_CENTER_X, 12'd0, 12'd2149,
      1'b0, jdv_pkg::DIR_STOP, jdv_pkg::DIR_STOP},
    '{1'b0, jdv_pkg::REG_CENTER_X, S_MAX, 12'd1948,
      1'b0, jdv_pkg::DIR_STOP, jdv_pkg::DIR_STOP},
    '{1'b0, jdv_pkg::REG_CENTER_X, 12'd0, 12'd1947,
      1'b0, jdv_pkg::DIR_STOP, jdv_pkg::DIR_STOP},
    '{1'b0, jdv_pkg::REG_CENTER_X, 12'd0, 12'd0,
      1'b0, jdv_pkg::DIR_STOP, jdv_pkg::DIR_STOP},
    '{1'b0, jdv_pkg::REG_CENTER_X, S_MAX, S_MAX,
      1'b0, jdv_pkg::DIR_STOP, jdv_pkg::DIR_STOP},
    // horizontal axis, zero deadzone, both center extremes
    '{1'b1, jdv_pkg::REG_AXIS_MODE, {10'd0, jdv_pkg::AXIS_HORIZ}, 12'd0,
      1'b0, jdv_pkg::DIR_STOP, jdv_pkg::DIR_STOP},
    '{1'b1, jdv_pkg::REG_CENTER_X, 12'd0, 12'd0,
      1'b0, jdv_pkg::DIR_STOP, jdv_pkg::DIR_STOP},
    '{1'b1, jdv_pkg::REG_DEADZONE, 12'd0, 12'd0,
      1'b0, jdv_pkg::DIR_STOP, jdv_pkg::DIR_STOP},
    '{1'b0, jdv_pkg::REG_CENTER_X, S_MAX, 12'd0,
      1'b0, jdv_pkg::DIR_STOP, jdv_pkg::DIR_STOP},
    '{1'b0, jdv_pkg::REG_CENTER_X, 12'd0, S_MAX,
      1'b0, jdv_pkg::DIR_STOP, jdv_pkg::DIR_STOP},
    '{1'b0, jdv_pkg::REG_CENTER_X, 12'd1, 12'd0,
      1'b0, jdv_pkg::DIR_STOP, jdv_pkg::DIR_STOP},
    '{1'b1, jdv_pkg::REG_CENTER_X, S_MAX, 12'd0,
      1'b0, jdv_pkg::DIR_STOP, jdv_pkg::DIR_STOP},
    '{1'b0, jdv_pkg::REG_CENTER_X, 12'd0, 12'd0,
      1'b0, jdv_pkg::DIR_STOP, jdv_pkg::DIR_STOP},
    '{1'b0, jdv_pkg::REG_CENTER_X, 12'd4094, 12'd0,
      1'b0, jdv_pkg::DIR_STOP, jdv_pkg::DIR_STOP},
    '{1'b0, jdv_pkg::REG_CENTER_X, S_MAX, 12'd0,
      1'b0, jdv_pkg::DIR_STOP, jdv_pkg::DIR_STOP},
    // mode 3 means nothing; upper data bits above the mode field are dropped
    '{1'b1, jdv_pkg::REG_AXIS_MODE, {10'h3FF, AXIS_UNUSED}, 12'd0,
      1'b0, jdv_pkg::DIR_STOP, jdv_pkg::DIR_STOP},
    '{1'b0, jdv_pkg::REG_CENTER_X, 12'd0, S_MAX,
      1'b0, jdv_pkg::DIR_STOP, jdv_pkg::DIR_STOP},
    '{1'b1, jdv_pkg::REG_AXIS_MODE, {10'h3FE, jdv_pkg::AXIS_VERT}, 12'd0,
      1'b0, jdv_pkg::DIR_STOP, jdv_pkg::DIR_STOP},
    '{1'b0, jdv_pkg::REG_CENTER_X, 12'd0, 12'd0,
      1'b0, jdv_pkg::DIR_STOP, jdv_pkg::DIR_STOP}
  };

  // ---- local model of the block ----
  logic [11:0] center_x_reg, center_y_reg, deadzone_reg;
  logic [1:0]  mode_reg;
  logic [2:0]  slot_codes [jdv_pkg::WINDOW];
  int          slot_next;

  vote_pair_t  pending_votes [$];
  int          bad_results = 0;

  // stream side control
  int src_idle_pct = 0;
  int rx_stall_pct = 0;
  int hold_req = 0;
  int hold_left = 0;
  int idle_cycles = 0;

  function automatic jdv_pkg::dir_t classify_sample(logic [11:0] xs, logic [11:0] ys);
    int offset;
    offset = 0;
    if (mode_reg == jdv_pkg::AXIS_VERT) begin
      offset = $signed({1'b0, ys}) - $signed({1'b0, center_y_reg});
      if ((offset < 0 ? -offset : offset) > int'(deadzone_reg))
        return (offset < 0) ? jdv_pkg::DIR_UP : jdv_pkg::DIR_DOWN;
    end else if (mode_reg == jdv_pkg::AXIS_HORIZ) begin
      offset = $signed({1'b0, xs}) - $signed({1'b0, center_x_reg});
      if ((offset < 0 ? -offset : offset) > int'(deadzone_reg))
        return (offset < 0) ? jdv_pkg::DIR_RIGHT : jdv_pkg::DIR_LEFT;
    end
    return jdv_pkg::DIR_STOP;
  endfunction

  // push one code into the window and take the vote, ties to the lower code
  function automatic vote_pair_t advance_vote_window(logic [11:0] xs, logic [11:0] ys);
    int            tally [jdv_pkg::DIR_KINDS];
    jdv_pkg::dir_t best;
    vote_pair_t    r;
    r.instant = classify_sample(xs, ys);
    slot_codes[slot_next] = r.instant;
    slot_next = (slot_next == jdv_pkg::WINDOW - 1) ? 0 : slot_next + 1;
    foreach (tally[k]) tally[k] = 0;
    foreach (slot_codes[k])
      if (slot_codes[k] != SLOT_EMPTY) tally[slot_codes[k]]++;
    best = jdv_pkg::DIR_STOP;
    for (int k = 1; k < jdv_pkg::DIR_KINDS; k++)
      if (tally[k] > tally[best]) best = jdv_pkg::dir_t'(k);
    r.voted = best;
    return r;
  endfunction

  // pick one axis reading around the center, following the current lean
  function automatic logic [11:0] axis_value(logic [11:0] center, logic [11:0] dz, int lean);
    int c, z, d, v;
    c = center;
    z = dz;
    case (lean)
      0: begin
        if ($urandom_range(1) == 1) d = z + int'($urandom_range(0, 4)) - 2;
        else d = int'($urandom_range(0, z + 3));
        v = ($urandom_range(1) == 1) ? c + d : c - d;
      end
      1: v = $urandom_range(0, c);
      2: v = $urandom_range(c, 4095);
      3: v = $urandom_range(0, 4095);
      default: v = ($urandom_range(1) == 1) ? 4095 : 0;
    endcase
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v[11:0];
  endfunction

  // ---- drivers ----
  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    cfg_valid     <= 1'b0;
    @(posedge clk);
    while (pending_votes.size() != 0) @(posedge clk);
  endtask

  // leaves cfg_valid high so back-to-back writes need no second assignment
  task automatic write_reg(logic [1:0] idx, logic [11:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      jdv_pkg::REG_CENTER_X:  center_x_reg = value;
      jdv_pkg::REG_CENTER_Y:  center_y_reg = value;
      jdv_pkg::REG_DEADZONE:  deadzone_reg = value;
      jdv_pkg::REG_AXIS_MODE: mode_reg     = value[1:0];
      default: ;
    endcase
  endtask

  task automatic send_sample(logic [11:0] xs, logic [11:0] ys, bit typed,
                             jdv_pkg::dir_t typed_vote, jdv_pkg::dir_t typed_inst);
    vote_pair_t pred;
    cfg_valid <= 1'b0;
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {ys, xs};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pred = advance_vote_window(xs, ys);
    if (typed) begin
      pred.voted   = typed_vote;
      pred.instant = typed_inst;
    end
    pending_votes.push_back(pred);
  endtask

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // ---- checking ----
  task automatic note_mismatch(string what, int want, int got);
    bad_results++;
    if (bad_results <= 10)
      $display("%0t mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
  endtask

  always @(posedge clk) begin
    vote_pair_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_votes.size() == 0) begin
        note_mismatch("unrequested result", -1, m_axis_tdata);
      end else begin
        want = pending_votes.pop_front();
        if (m_axis_tdata[2:0] !== want.voted)
          note_mismatch("voted_direction", want.voted, m_axis_tdata[2:0]);
        if (m_axis_tdata[5:3] !== want.instant)
          note_mismatch("instant_direction", want.instant, m_axis_tdata[5:3]);
        if (m_axis_tdata[7:6] !== 2'b00)
          note_mismatch("pad bits", 0, m_axis_tdata[7:6]);
      end
    end
  end

  // watchdog: any handshake on any channel counts as progress
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t no progress for %0d cycles", $realtime, STALL_LIMIT);
      $display("** joystick_direction_vote: FAILED **");
      $finish;
    end
  end

  // ---- sequence ----
  initial begin
    directed_row_t row;
    logic [11:0]   xs, ys, mode_word;
    logic [9:0]    junk;
    int            run_left, lean_x, lean_y;
    center_x_reg = '0;
    center_y_reg = '0;
    deadzone_reg = '0;
    mode_reg     = jdv_pkg::AXIS_NONE;
    foreach (slot_codes[k]) slot_codes[k] = SLOT_EMPTY;
    slot_next = 0;
    run_left  = 0;
    lean_x    = 3;
    lean_y    = 3;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int k = 0; k < N_DIRECTED; k++) begin
      row = DIRECTED[k];
      if (row.is_reg) begin
        wait_drain();
        write_reg(row.reg_index, row.a);
      end else begin
        send_sample(row.a, row.b, row.typed, row.voted, row.instant);
      end
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      wait_drain();
      junk = $urandom;
      // first four phases pin fixed register settings, the rest draw random centers and deadzones
      case (phase)
        0: begin
          write_reg(jdv_pkg::REG_CENTER_X, 12'd2048);
          write_reg(jdv_pkg::REG_CENTER_Y, 12'd2048);
          write_reg(jdv_pkg::REG_DEADZONE, 12'd100);
          mode_word = {10'd0, jdv_pkg::AXIS_VERT};
        end
        1: begin
          write_reg(jdv_pkg::REG_CENTER_X, 12'd0);
          write_reg(jdv_pkg::REG_CENTER_Y, 12'd0);
          write_reg(jdv_pkg::REG_DEADZONE, 12'd0);
          mode_word = {10'd0, jdv_pkg::AXIS_HORIZ};
        end
        2: begin
          write_reg(jdv_pkg::REG_CENTER_X, S_MAX);
          write_reg(jdv_pkg::REG_CENTER_Y, S_MAX);
          write_reg(jdv_pkg::REG_DEADZONE, S_MAX);
          mode_word = {10'd0, jdv_pkg::AXIS_VERT};
        end
        3: begin
          write_reg(jdv_pkg::REG_CENTER_X, S_MAX);
          write_reg(jdv_pkg::REG_CENTER_Y, 12'd0);
          write_reg(jdv_pkg::REG_DEADZONE, 12'd4094);
          mode_word = {10'd0, jdv_pkg::AXIS_HORIZ};
        end
        default: begin
          write_reg(jdv_pkg::REG_CENTER_X, 12'($urandom_range(0, 4095)));
          write_reg(jdv_pkg::REG_CENTER_Y, 12'($urandom_range(0, 4095)));
          write_reg(jdv_pkg::REG_DEADZONE, (phase == 4) ? 12'($urandom_range(0, 400))
                                                        : 12'($urandom_range(0, 4095)));
          case (phase)
            4:       mode_word = {10'd0, jdv_pkg::AXIS_VERT};
            5:       mode_word = {junk, jdv_pkg::AXIS_HORIZ};
            6:       mode_word = {junk, AXIS_UNUSED};
            default: mode_word = 12'($urandom_range(0, 4095));
          endcase
        end
      endcase
      write_reg(jdv_pkg::REG_AXIS_MODE, mode_word);

      case (phase % 4)
        0: begin src_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin src_idle_pct = 72; rx_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  rx_stall_pct = 72; end
        default: begin src_idle_pct = 27; rx_stall_pct = 27; end
      endcase

      for (int n = 0; n < ITEMS_PHASE; n++) begin
        // receiver holds off while the sender keeps pushing: pipe fills up
        if (phase == 4 && n == 100) hold_req = LONG_HOLD;
        // sender pauses until every result is back
        if (phase == 5 && n == 110) wait_drain();
        if (run_left == 0) begin
          run_left = $urandom_range(3, 20);
          lean_x   = $urandom_range(0, 4);
          lean_y   = $urandom_range(0, 4);
        end
        run_left--;
        xs = axis_value(center_x_reg, deadzone_reg, lean_x);
        ys = axis_value(center_y_reg, deadzone_reg, lean_y);
        send_sample(xs, ys, 1'b0, jdv_pkg::DIR_STOP, jdv_pkg::DIR_STOP);
      end
    end

    wait_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (bad_results == 0 && pending_votes.size() == 0)
      $display("** joystick_direction_vote: PASSED **");
    else
      $display("** joystick_direction_vote: FAILED **");
    $finish;
  end

endmodule

// ===== files.f =====
design/jdv_pkg.sv
design/jdv_classify.sv
design/jdv_cell.sv
design/jdv_tally.sv
design/joystick_direction_vote.sv
design/jdv_checker.sv
bench/joystick_direction_vote_test.sv
